// ===== design/mpts_pkg.sv =====
package mpts_pkg;

	// Position within the header that is being parsed, one-hot.
	typedef enum logic [7:0] {
		PH_SEARCH     = 8'b0000_0001,
		PH_PIC0       = 8'b0000_0010,
		PH_PIC1       = 8'b0000_0100,
		PH_EXT0       = 8'b0000_1000,
		PH_EXT1_ID8   = 8'b0001_0000,
		PH_EXT1_OTHER = 8'b0010_0000,
		PH_EXT2       = 8'b0100_0000,
		PH_SKIP       = 8'b1000_0000
	} phase_t;

	// Start code search.
	localparam logic [23:0] HIST_RESET   = 24'hFF_FFFF;
	localparam logic [23:0] START_PREFIX = 24'h00_0001;
	localparam logic [7:0]  CODE_PICTURE = 8'h00;
	localparam logic [7:0]  CODE_EXT     = 8'hB5;
	localparam logic [3:0]  EXT_ID_PCE   = 4'h8;

	// Picture coding types as carried in the picture header.
	localparam logic [2:0] PCT_I = 3'd1;
	localparam logic [2:0] PCT_P = 3'd2;
	localparam logic [2:0] PCT_B = 3'd3;
	localparam logic [2:0] PCT_D = 3'd4;

	// Picture structure codes in the picture coding extension.
	localparam logic [1:0] PS_TOP    = 2'd1;
	localparam logic [1:0] PS_BOTTOM = 2'd2;

	// Reported frame types.
	localparam logic [1:0] FT_UNKNOWN = 2'd0;
	localparam logic [1:0] FT_KEY     = 2'd1;
	localparam logic [1:0] FT_PRED    = 2'd2;
	localparam logic [1:0] FT_BIDIR   = 2'd3;

	// Reported field structures.
	localparam logic [1:0] FS_FRAME  = 2'd0;
	localparam logic [1:0] FS_TOP    = 2'd1;
	localparam logic [1:0] FS_BOTTOM = 2'd2;

	// Picture counter.
	localparam logic [1:0] PIC_NONE = 2'd0;
	localparam logic [1:0] PIC_SAT  = 2'd2;

	// Header bytes passed over after each decoded field.
	localparam logic [1:0] SKIP_PIC     = 2'd2;
	localparam logic [1:0] SKIP_EXT_PCE = 2'd3;
	localparam logic [1:0] SKIP_STRUCT  = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} stage_t;

	typedef struct packed {
		logic [1:0] frame_type;
		logic [1:0] field_structure;
		logic [1:0] picture_count;
	} result_t;

endpackage

// ===== design/mpts_in_if.sv =====
interface mpts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== design/mpts_out_if.sv =====
interface mpts_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] frame_type;
	logic [1:0] field_structure;
	logic [1:0] picture_count;

	modport source (output valid, output frame_type, output field_structure,
		output picture_count, input ready);
	modport sink (input valid, input frame_type, input field_structure,
		input picture_count, output ready);
endinterface

// ===== design/mpts_in_stage.sv =====
module mpts_in_stage import mpts_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	mpts_in_if.sink in_ch,
	input  logic   advance,
	output stage_t stage
);

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	// The stage takes a new item when it is empty or its item moves on now.
	assign in_ch.ready = !valid_s1 || advance;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data_byte <= in_ch.data_byte;
			item_s1.last_byte <= in_ch.last_byte;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

endmodule

// ===== design/mpts_parser.sv =====
module mpts_parser import mpts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  stage_t  stage,
	input  logic    out_free,
	output logic    advance,
	output logic    res_valid,
	output result_t result
);

	logic [23:0] recent_q, recent_n;
	phase_t      phase_q, phase_n;
	logic [1:0]  skip_q, skip_n;
	logic [1:0]  pics_q, pics_n;
	logic        after_q, after_n;
	logic [1:0]  frame_q, frame_n;
	logic [1:0]  field_q, field_n;
	logic        stopped_q, stopped_n;
	logic [7:0]  b;

	assign b = stage.item.data_byte;

	// A final byte may only move on when the output register can take the result.
	assign advance   = stage.valid && (!stage.item.last_byte || out_free);
	assign res_valid = advance && stage.item.last_byte;

	// Next parser state for the byte held in the input stage.
	always_comb begin
		recent_n  = recent_q;
		phase_n   = phase_q;
		skip_n    = skip_q;
		pics_n    = pics_q;
		after_n   = after_q;
		frame_n   = frame_q;
		field_n   = field_q;
		stopped_n = stopped_q;
		if (!stopped_q) begin
			case (phase_q)
				PH_SEARCH: begin
					if (recent_q == START_PREFIX) begin
						recent_n = HIST_RESET;
						if (b == CODE_PICTURE) begin
							phase_n = PH_PIC0;
						end else if (b == CODE_EXT) begin
							phase_n = PH_EXT0;
						end
					end else begin
						recent_n = {recent_q[15:0], b};
					end
				end
				PH_PIC0: begin
					phase_n = PH_PIC1;
				end
				PH_PIC1: begin
					// Only the first picture of the frame sets the type.
					if (pics_q == PIC_NONE) begin
						case (b[5:3])
							PCT_I:        frame_n = FT_KEY;
							PCT_P, PCT_D: frame_n = FT_PRED;
							PCT_B:        frame_n = FT_BIDIR;
							default:      frame_n = frame_q;
						endcase
					end
					if (pics_q < PIC_SAT) begin
						pics_n = pics_q + 2'd1;
					end
					after_n = 1'b1;
					skip_n  = SKIP_PIC;
					phase_n = PH_SKIP;
				end
				PH_EXT0: begin
					phase_n = (b[7:4] == EXT_ID_PCE) ? PH_EXT1_ID8 : PH_EXT1_OTHER;
				end
				PH_EXT1_OTHER: begin
					after_n = 1'b0;
					phase_n = PH_SEARCH;
				end
				PH_EXT1_ID8: begin
					if (pics_q >= PIC_SAT) begin
						field_n   = FS_FRAME;
						stopped_n = 1'b1;
						phase_n   = PH_SEARCH;
					end else if (!after_q) begin
						skip_n  = SKIP_EXT_PCE;
						phase_n = PH_SKIP;
					end else begin
						after_n = 1'b0;
						phase_n = PH_EXT2;
					end
				end
				PH_EXT2: begin
					case (b[1:0])
						PS_TOP:    field_n = FS_TOP;
						PS_BOTTOM: field_n = FS_BOTTOM;
						default:   field_n = field_q;
					endcase
					skip_n  = SKIP_STRUCT;
					phase_n = PH_SKIP;
				end
				PH_SKIP: begin
					if (skip_q <= 2'd1) begin
						skip_n  = 2'd0;
						phase_n = PH_SEARCH;
					end else begin
						skip_n = skip_q - 2'd1;
					end
				end
				default: begin
					phase_n = PH_SEARCH;
				end
			endcase
		end
	end

	// The result carries the state after the final byte has been parsed.
	assign result.frame_type      = frame_n;
	assign result.field_structure = field_n;
	assign result.picture_count   = pics_n;

	// Parser state; the final byte of a frame returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q  <= HIST_RESET;
			phase_q   <= PH_SEARCH;
			skip_q    <= 2'd0;
			pics_q    <= PIC_NONE;
			after_q   <= 1'b0;
			frame_q   <= FT_UNKNOWN;
			field_q   <= FS_FRAME;
			stopped_q <= 1'b0;
		end else if (advance) begin
			if (stage.item.last_byte) begin
				recent_q  <= HIST_RESET;
				phase_q   <= PH_SEARCH;
				skip_q    <= 2'd0;
				pics_q    <= PIC_NONE;
				after_q   <= 1'b0;
				frame_q   <= FT_UNKNOWN;
				field_q   <= FS_FRAME;
				stopped_q <= 1'b0;
			end else begin
				recent_q  <= recent_n;
				phase_q   <= phase_n;
				skip_q    <= skip_n;
				pics_q    <= pics_n;
				after_q   <= after_n;
				frame_q   <= frame_n;
				field_q   <= field_n;
				stopped_q <= stopped_n;
			end
		end
	end

endmodule

// ===== design/mpts_out_reg.sv =====
module mpts_out_reg import mpts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	output logic    free,
	mpts_out_if.source out_ch
);

	logic    valid_q;
	result_t res_q;

	// The register can be loaded when it is empty or being emptied now.
	assign free = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign out_ch.valid           = valid_q;
	assign out_ch.frame_type      = res_q.frame_type;
	assign out_ch.field_structure = res_q.field_structure;
	assign out_ch.picture_count   = res_q.picture_count;

endmodule

// ===== design/mpeg2_picture_type_scanner.sv =====
// Throughput: one byte per cycle, except while a frame's last byte waits for the result register.
// A frame's last byte is held in the input register, and the parser's result for it is then
// loaded into the result register.
// A waiting result does not stop the intake of the next frame's bytes; only that frame's
// own last byte is held in the input register until the result register is free.
// Reset (arst_n low, asynchronous) empties both registers and returns the
// parser to the start code search with no pictures counted.
module mpeg2_picture_type_scanner import mpts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	mpts_in_if.sink    in_ch,
	mpts_out_if.source out_ch
);

	stage_t  stage;
	logic    advance;
	logic    res_valid;
	logic    out_free;
	result_t result;

	// Input register.
	mpts_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.advance (advance),
		.stage   (stage)
	);

	// Header parser and its state.
	mpts_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (stage),
		.out_free  (out_free),
		.advance   (advance),
		.res_valid (res_valid),
		.result    (result)
	);

	// Result register.
	mpts_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.result (result),
		.free   (out_free),
		.out_ch (out_ch)
	);

endmodule

// ===== design/mpts_checker.sv =====
module mpts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] frame_type,
	input logic [1:0] field_structure,
	input logic [1:0] picture_count
);

	// A result that is not taken stays, unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_type)
			&& $stable(field_structure) && $stable(picture_count))
		else $error("result changed or vanished while stalled");

	// The count saturates at two and no structure code above bottom exists.
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> picture_count != 2'd3 && field_structure != 2'd3)
		else $error("result field out of range");

	// Without a picture header neither type nor structure can be known.
	a_no_picture: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && picture_count == 2'd0 |-> frame_type == 2'd0
			&& field_structure == 2'd0)
		else $error("type or structure reported without a picture");

	// A fresh result follows an item taken on the input.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a matching item");

endmodule

bind mpeg2_picture_type_scanner mpts_checker u_mpts_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.frame_type      (out_ch.frame_type),
	.field_structure (out_ch.field_structure),
	.picture_count   (out_ch.picture_count)
);

// ===== verif/mpeg2_picture_type_scanner_tb.sv =====
module mpeg2_picture_type_scanner_tb;
	import mpts_pkg::*;

	localparam int unsigned RANDOM_BYTES = 1450;
	localparam int unsigned TOTAL_BYTES  = 1950;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned REPORT_LIMIT = 10;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mpts_in_if  in_ch();
	mpts_out_if out_ch();

	mpeg2_picture_type_scanner u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Free-running clock, period of four time units.
	initial begin
		forever #2 clk = ~clk;
	end

	// Shadow copy of the scanner state, advanced on every accepted byte.
	logic [23:0] prefix_hist;
	phase_t      scan_phase;
	logic [1:0]  skip_left;
	logic [1:0]  pictures;
	logic        after_pic;
	logic [1:0]  kind;
	logic [1:0]  structure;
	logic        scan_halted;

	result_t     pending_reports[$];
	logic [7:0]  frame_bytes[$];

	bit          idle_enable;
	int unsigned cycle_count;
	int unsigned bytes_sent;
	int unsigned frames_sent;
	int unsigned reports_checked;
	int unsigned fail_count;
	int unsigned scans_halted;
	int unsigned field_reports;
	int unsigned type_reports[4];

	// Return the shadow state to its value at the start of a frame.
	function automatic void clear_scan();
		prefix_hist = HIST_RESET;
		scan_phase  = PH_SEARCH;
		skip_left   = '0;
		pictures    = PIC_NONE;
		after_pic   = 1'b0;
		kind        = FT_UNKNOWN;
		structure   = FS_FRAME;
		scan_halted = 1'b0;
	endfunction

	// Advance the shadow scanner by one byte; returns 1 when the byte closes a frame.
	function automatic bit track_byte(input logic [7:0] value, input logic last,
			output result_t report);
		logic [2:0] coding;
		report = '0;
		if (!scan_halted) begin
			case (scan_phase)
			PH_SEARCH: begin
				if (prefix_hist == START_PREFIX) begin
					prefix_hist = HIST_RESET;
					if (value == CODE_PICTURE)
						scan_phase = PH_PIC0;
					else if (value == CODE_EXT)
						scan_phase = PH_EXT0;
				end else begin
					prefix_hist = {prefix_hist[15:0], value};
				end
			end
			PH_PIC0: scan_phase = PH_PIC1;
			PH_PIC1: begin
				// Only the first picture of a frame sets the type.
				if (pictures == PIC_NONE) begin
					coding = value[5:3];
					case (coding)
					PCT_I:        kind = FT_KEY;
					PCT_P, PCT_D: kind = FT_PRED;
					PCT_B:        kind = FT_BIDIR;
					default: ;
					endcase
				end
				if (pictures < PIC_SAT)
					pictures++;
				after_pic  = 1'b1;
				skip_left  = SKIP_PIC;
				scan_phase = PH_SKIP;
			end
			PH_EXT0: scan_phase = (value[7:4] == EXT_ID_PCE) ? PH_EXT1_ID8 : PH_EXT1_OTHER;
			PH_EXT1_OTHER: begin
				after_pic  = 1'b0;
				scan_phase = PH_SEARCH;
			end
			PH_EXT1_ID8: begin
				if (pictures >= PIC_SAT) begin
					structure   = FS_FRAME;
					scan_halted = 1'b1;
					scan_phase  = PH_SEARCH;
				end else if (!after_pic) begin
					skip_left  = SKIP_EXT_PCE;
					scan_phase = PH_SKIP;
				end else begin
					after_pic  = 1'b0;
					scan_phase = PH_EXT2;
				end
			end
			PH_EXT2: begin
				if (value[1:0] == PS_TOP)
					structure = FS_TOP;
				else if (value[1:0] == PS_BOTTOM)
					structure = FS_BOTTOM;
				skip_left  = SKIP_STRUCT;
				scan_phase = PH_SKIP;
			end
			default: begin
				if (skip_left > 0)
					skip_left--;
				if (skip_left == 0)
					scan_phase = PH_SEARCH;
			end
			endcase
		end
		if (!last)
			return 1'b0;
		if (scan_halted)
			scans_halted++;
		report.frame_type      = kind;
		report.field_structure = structure;
		report.picture_count   = pictures;
		clear_scan();
		return 1'b1;
	endfunction

	// Frame builders: each appends one header or a run of filler to the frame.
	function automatic void add_start(input logic [7:0] code);
		frame_bytes.push_back(8'h00);
		frame_bytes.push_back(8'h00);
		frame_bytes.push_back(8'h01);
		frame_bytes.push_back(code);
	endfunction

	function automatic void add_picture(input logic [2:0] coding);
		add_start(CODE_PICTURE);
		frame_bytes.push_back(8'($urandom));
		frame_bytes.push_back({2'($urandom), coding, 3'($urandom)});
		frame_bytes.push_back(8'($urandom));
		frame_bytes.push_back(8'($urandom));
	endfunction

	function automatic void add_extension(input logic [3:0] id, input logic [1:0] pic_struct);
		add_start(CODE_EXT);
		frame_bytes.push_back({id, 4'($urandom)});
		frame_bytes.push_back(8'($urandom));
		frame_bytes.push_back({6'($urandom), pic_struct});
		frame_bytes.push_back(8'($urandom));
		frame_bytes.push_back(8'($urandom));
	endfunction

	function automatic void add_filler(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			frame_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
	endfunction

	// Mostly well-formed headers in random order, sometimes cut short by the frame end.
	function automatic void build_random_frame();
		int unsigned parts;
		int unsigned keep;
		parts = $urandom_range(1, 5);
		for (int unsigned i = 0; i < parts; i++) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3: add_picture(3'($urandom));
			4, 5, 6:    add_extension(EXT_ID_PCE, 2'($urandom));
			7:          add_extension(4'($urandom), 2'($urandom));
			8:          add_start(8'($urandom));
			default:    add_filler($urandom_range(1, 4));
			endcase
		end
		if ($urandom_range(0, 4) == 0) begin
			keep = $urandom_range(1, frame_bytes.size());
			while (frame_bytes.size() > keep)
				void'(frame_bytes.pop_back());
		end
	endfunction

	// Offer one item and wait for its acceptance; inputs change on the falling edge.
	task automatic send_byte(input logic [7:0] value, input logic last);
		result_t report;
		if (idle_enable && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= value;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
		if (track_byte(value, last, report))
			pending_reports.push_back(report);
		@(negedge clk);
	endtask

	// Send the built frame with the last flag on its final byte.
	task automatic send_frame();
		for (int unsigned i = 0; i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		frame_bytes.delete();
		frames_sent++;
	endtask

	// Frames of one byte, and a frame whose picture coding extension after its second picture stops the scan.
	task automatic test_directed_frames();
		frame_bytes.push_back(8'hFF);
		send_frame();
		add_picture(PCT_D);
		add_picture(PCT_I);
		add_start(CODE_EXT);
		frame_bytes.push_back({EXT_ID_PCE, 4'h0});
		frame_bytes.push_back(8'hFF);
		send_frame();
		frame_bytes.push_back(8'h00);
		send_frame();
	endtask

	// Random frames with idling switched on and off from frame to frame.
	task automatic test_random_frames(input int unsigned byte_target);
		while (bytes_sent < byte_target) begin
			idle_enable = ($urandom_range(0, 3) != 0);
			build_random_frame();
			send_frame();
		end
	endtask

	// Back-to-back items and an always-ready receiver.
	task automatic test_full_rate(input int unsigned byte_target);
		idle_enable = 1'b0;
		while (bytes_sent < byte_target) begin
			build_random_frame();
			send_frame();
		end
	endtask

	// Compare an accepted frame report with the oldest prediction.
	task automatic check_report();
		result_t want;
		result_t got;
		got.frame_type      = out_ch.frame_type;
		got.field_structure = out_ch.field_structure;
		got.picture_count   = out_ch.picture_count;
		if (pending_reports.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("Unexpected frame report: type %0d field %0d count %0d",
					got.frame_type, got.field_structure, got.picture_count);
		end else begin
			want = pending_reports.pop_front();
			reports_checked++;
			type_reports[want.frame_type]++;
			if (want.field_structure != FS_FRAME)
				field_reports++;
			if (got.frame_type != want.frame_type ||
					got.field_structure != want.field_structure ||
					got.picture_count != want.picture_count) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display({"Report %0d mismatch: expected type %0d field %0d count %0d,",
						" got type %0d field %0d count %0d"}, reports_checked,
						want.frame_type, want.field_structure, want.picture_count,
						got.frame_type, got.field_structure, got.picture_count);
			end
		end
	endtask

	// Results are sampled on the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			check_report();
	end

	// Receiver back-pressure in random bursts.
	initial begin : sink_pacing
		int unsigned hold;
		hold = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ch.ready <= 1'b0;
				hold--;
			end else begin
				out_ch.ready <= 1'b1;
				if (idle_enable && $urandom_range(0, 11) == 0)
					hold = $urandom_range(1, 9);
			end
		end
	end

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// Test sequence.
	initial begin
		in_ch.valid     = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		idle_enable     = 1'b1;
		clear_scan();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_frames();
		test_random_frames(RANDOM_BYTES);
		test_full_rate(TOTAL_BYTES);

		in_ch.valid <= 1'b0;
		wait (pending_reports.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_reports.size() != 0)
			fail_count++;

		$display("Sent %0d bytes in %0d frames and checked %0d frame reports.",
			bytes_sent, frames_sent, reports_checked);
		$display({"Types unknown/key/pred/bidir %0d/%0d/%0d/%0d,",
			" field set %0d, scans stopped %0d."},
			type_reports[0], type_reports[1], type_reports[2], type_reports[3],
			field_reports, scans_halted);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
